FILE: rtl/core/image_upscale_2x_interp_defines.svh
// assertion macros for the 2x upscaler checker
// no dependencies; taken in by the checker file
`ifndef IMAGE_UPSCALE_2X_INTERP_DEFINES_SVH
`define IMAGE_UPSCALE_2X_INTERP_DEFINES_SVH

// implication in the same cycle, off while reset is high
`define UPX_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication in the next cycle, off while reset is high
`define UPX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// implication in the next cycle, also checked during reset
`define UPX_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/upx_pkg.sv
// shared types and constants of the 2x upscaler
// no dependencies; used by every module of the block
package upx_pkg;

   // fixed field widths of the ports
   localparam int COORD_W     = 11;
   localparam int PIX_FIELD_W = 16;
   localparam int CFG_W       = 11;
   localparam int CSR_IDX_W   = 1;
   localparam int RSP_TDATA_W = 40;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IN_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_HEIGHT = 1'd1;

   // reset value of both dimension registers
   localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

   // descriptor queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // row or column slot around the base coordinate of a request
   typedef logic [1:0] upx_slot_type;
   localparam upx_slot_type SLOT_BEFORE = 2'd0;
   localparam upx_slot_type SLOT_AT     = 2'd1;
   localparam upx_slot_type SLOT_AFTER  = 2'd2;

   // classification of one request, handed from front to back
   typedef struct packed {
      logic               has_above;
      logic               has_left;
      logic               last_col;
      logic               last_row;
      logic [COORD_W-1:0] row2;
      logic [COORD_W-1:0] col2;
   } upx_tag_type;

   localparam int TAG_W = $bits(upx_tag_type);

   // queue status seen by the front
   typedef struct packed {
      logic full;
      logic empty;
   } upx_qstat_type;

endpackage

FILE: rtl/core/image_upscale_2x_interp.sv
// 2x upscaler with interpolation. Source pixels come in on req_ in raster order,
// in_width per row and in_height rows per frame; each request gives one to nine
// output pixels on rsp_, tagged with their output row and column and ordered by
// row then column, tlast on the last one of the request. A request is taken
// every cycle while the four-entry descriptor queue has room; the result side
// sends one pixel a cycle while rsp_tready is high, so with four results per
// request on average the sustained intake is set by that single result port.
// Writing either register restarts the frame at row 0, column 0.
// depends on upx_pkg, upx_front, upx_queue, upx_back
module image_upscale_2x_interp
   import upx_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   // requests
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIX_FIELD_W-1:0] req_tdata,   // [15:0] pixel_in
   // results
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [10:0] out_row, [21:11] out_col,
                                               // [37:22] pixel_out, [39:38] zero
   output logic                   rsp_tlast    // run_last
);

   localparam int PIX_W  = (PIXEL_BITS < PIX_FIELD_W) ? PIXEL_BITS : PIX_FIELD_W;
   localparam int DESC_W = TAG_W + 4 * PIX_W;

   upx_qstat_type      qstat;
   logic               push, pop;
   upx_tag_type        push_tag;
   logic [4*PIX_W-1:0] push_pix;
   logic [DESC_W-1:0]  head_data;
   upx_tag_type        head_tag;
   logic [4*PIX_W-1:0] head_pix;

   // request intake and classification
   upx_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIX_W      (PIX_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pixel  (req_tdata[PIX_W-1:0]),
      .qstat     (qstat),
      .push      (push),
      .push_tag  (push_tag),
      .push_pix  (push_pix)
   );

   // descriptor queue
   upx_queue #(
      .DATA_W (DESC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_pix, push_tag}),
      .pop       (pop),
      .head_data (head_data),
      .stat      (qstat)
   );

   assign head_tag = upx_tag_type'(head_data[TAG_W-1:0]);
   assign head_pix = head_data[DESC_W-1:TAG_W];

   // result expansion
   upx_back #(
      .PIX_W (PIX_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!qstat.empty),
      .head_tag   (head_tag),
      .head_pix   (head_pix),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/core/upx_queue.sv
// short descriptor queue between the front and back parts
// depends on upx_pkg
module upx_queue
   import upx_pkg::*;
#(
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] head_data,
   output upx_qstat_type     stat
);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // status
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/upx_front.sv
// front part: takes source pixels, keeps the line store and computes the means
// depends on upx_pkg
module upx_front
   import upx_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int PIX_W      = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [PIX_W-1:0]       in_pixel,
   input  upx_qstat_type          qstat,
   output logic                   push,
   output upx_tag_type            push_tag,
   output logic [4*PIX_W-1:0]     push_pix
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW    = COL_W + 1;
   localparam int RW    = ROW_W + 1;

   logic [CFG_W-1:0] width_ff, height_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CW-1:0]    w_eff;
   logic [RW-1:0]    h_eff;
   logic             last_col, last_row;
   logic             accept;

   logic [PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [PIX_W-1:0] above_ff;

   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pix_ff;
   upx_tag_type      s1_tag_ff;
   logic [PIX_W-1:0] left_ff, left_above_ff;

   logic [PIX_W:0]   sum_here, sum_left, sum_h, sum_d;
   logic [PIX_W-1:0] vmean_here, vmean_left, hmean, dmean;

   // dimensions clamped into range
   always_comb begin
      if (width_ff == '0) begin
         w_eff = CW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = RW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = RW'(MAX_HEIGHT);
      end else begin
         h_eff = RW'(height_ff);
      end
   end

   // position of the next source pixel
   assign last_col = (CW'(col_ff) + CW'(1) >= w_eff);
   assign last_row = (RW'(row_ff) + RW'(1) >= h_eff);
   assign push     = s1_valid_ff && !qstat.full;
   assign in_ready = !s1_valid_ff || !qstat.full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // configuration registers and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         if (csr_we && csr_index == CSR_IN_WIDTH) begin
            width_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_IN_HEIGHT) begin
            height_ff <= csr_wdata;
         end
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line store: old entry read out as the new pixel replaces it
   always_ff @(posedge clock) begin
      if (accept) begin
         above_ff         <= line_mem[col_ff];
         line_mem[col_ff] <= in_pixel;
      end
   end

   // second stage holds the pixel and its classification
   assign s1_valid_in = accept ? 1'b1 : (push ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         left_ff       <= '0;
         left_above_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (push) begin
            left_ff       <= s1_pix_ff;
            left_above_ff <= above_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff           <= in_pixel;
         s1_tag_ff.has_above <= (row_ff != '0);
         s1_tag_ff.has_left  <= (col_ff != '0);
         s1_tag_ff.last_col  <= last_col;
         s1_tag_ff.last_row  <= last_row;
         s1_tag_ff.row2      <= COORD_W'({row_ff, 1'b0});
         s1_tag_ff.col2      <= COORD_W'({col_ff, 1'b0});
      end
   end

   // floored means, widened by one bit so nothing overflows
   always_comb begin
      sum_here   = {1'b0, above_ff} + {1'b0, s1_pix_ff};
      sum_left   = {1'b0, left_above_ff} + {1'b0, left_ff};
      sum_h      = {1'b0, left_ff} + {1'b0, s1_pix_ff};
      vmean_here = sum_here[PIX_W:1];
      vmean_left = sum_left[PIX_W:1];
      hmean      = sum_h[PIX_W:1];
      sum_d      = {1'b0, vmean_left} + {1'b0, vmean_here};
      dmean      = sum_d[PIX_W:1];
   end

   // descriptor: pixel, horizontal mean, vertical mean, diagonal mean
   assign push_tag = s1_tag_ff;
   assign push_pix = {dmean, vmean_here, hmean, s1_pix_ff};

endmodule

FILE: rtl/core/upx_back.sv
// back part: expands one descriptor into its output pixels, one per cycle while rsp_tready is high
// depends on upx_pkg
module upx_back
   import upx_pkg::*;
#(
   parameter int PIX_W = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  upx_tag_type              head_tag,
   input  logic [4*PIX_W-1:0]       head_pix,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                     rsp_tlast
);

   localparam int PAD_W = RSP_TDATA_W - 2 * COORD_W - PIX_FIELD_W;

   logic               active_ff, active_in;
   upx_slot_type       rs_ff, rs_in, cs_ff, cs_in;
   upx_slot_type       start_rs, start_cs, last_rs, last_cs, cur_rs, cur_cs;
   logic               load, is_last;
   logic [PIX_W-1:0]   p, hmean, vmean, dmean, here, mid, value;
   logic [COORD_W-1:0] orow, ocol;

   logic                   valid_ff, valid_in;
   logic [COORD_W-1:0]     row_ff, col_ff;
   logic [PIX_W-1:0]       pix_ff;
   logic                   last_ff;

   assign {dmean, vmean, hmean, p} = head_pix;

   // slot walk: rows then columns within the request's window
   always_comb begin
      start_rs = head_tag.has_above ? SLOT_BEFORE : SLOT_AT;
      start_cs = head_tag.has_left ? SLOT_BEFORE : SLOT_AT;
      last_rs  = head_tag.last_row ? SLOT_AFTER : SLOT_AT;
      last_cs  = head_tag.last_col ? SLOT_AFTER : SLOT_AT;
      cur_rs   = active_ff ? rs_ff : start_rs;
      cur_cs   = active_ff ? cs_ff : start_cs;
      is_last  = (cur_rs == last_rs) && (cur_cs == last_cs);
      load     = head_valid && (!valid_ff || rsp_tready);
      pop      = load && is_last;
   end

   // value and coordinates of the current slot
   always_comb begin
      here  = (cur_rs == SLOT_BEFORE) ? vmean : p;
      mid   = (cur_rs == SLOT_BEFORE) ? dmean : hmean;
      value = (cur_cs == SLOT_BEFORE) ? mid : here;
      orow  = head_tag.row2 + COORD_W'(cur_rs) - COORD_W'(1);
      ocol  = head_tag.col2 + COORD_W'(cur_cs) - COORD_W'(1);
   end

   // next slot
   always_comb begin
      active_in = active_ff;
      rs_in     = rs_ff;
      cs_in     = cs_ff;
      if (load) begin
         active_in = !is_last;
         if (cur_cs == last_cs) begin
            rs_in = cur_rs + 1'b1;
            cs_in = start_cs;
         end else begin
            rs_in = cur_rs;
            cs_in = cur_cs + 1'b1;
         end
      end
   end

   assign valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rs_ff     <= SLOT_BEFORE;
         cs_ff     <= SLOT_BEFORE;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         rs_ff     <= rs_in;
         cs_ff     <= cs_in;
         valid_ff  <= valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load) begin
         row_ff  <= orow;
         col_ff  <= ocol;
         pix_ff  <= value;
         last_ff <= is_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {PAD_W'(0), PIX_FIELD_W'(pix_ff), col_ff, row_ff};

endmodule

FILE: rtl/core/upx_checker.sv
// port-level checks on the 2x upscaler, bound to the top level
// depends on upx_pkg and image_upscale_2x_interp_defines.svh
`include "image_upscale_2x_interp_defines.svh"

module upx_checker
   import upx_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast
);

   // a stalled result keeps its contents
   `UPX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
                    "result changed while stalled")

   // reset empties the output register
   `UPX_ASSERT_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_tvalid,
                           "result valid after reset")

   // a request's results follow one another without a gap
   `UPX_ASSERT_NEXT(a_run_gapless, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast,
                    rsp_tvalid, "gap inside a request's results")

   // the block is open for requests as soon as reset ends
   `UPX_ASSERT_SAME(a_ready_after_reset, clock, reset, $fell(reset), req_tready,
                    "not ready after reset")

endmodule

bind image_upscale_2x_interp upx_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
